/* rtl/fisr_pkg.sv */
// Shared constants and float helper functions for the reciprocal square root block.
`timescale 1ns / 1ps
package fisr_pkg;

  localparam logic [31:0] MAGIC_GUESS  = 32'h5f3759df;
  localparam logic [31:0] HALF_BITS    = 32'h3f000000;  // 0.5f
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;  // 1.5f
  localparam logic [31:0] CANON_NAN    = 32'h7fc00000;
  localparam logic [7:0]  EXP_MAX      = 8'hff;
  localparam int          MANT_W       = 48;

  typedef logic [31:0] word_t;
  typedef logic [MANT_W-1:0] mant_t;
  typedef logic signed [9:0] sexp_t;

  // Leading zero count of a 48-bit significand; 48 when zero.
  function automatic logic [5:0] lzc48(input mant_t p);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < MANT_W; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Value is p * 2^(e - 173). Normalize (or denormalize), round to nearest even, pack.
  function automatic word_t fp_pack(input logic sgn, input sexp_t e, input logic [5:0] lz,
                                    input mant_t p);
    logic signed [10:0] es;
    logic signed [10:0] lzs;
    logic signed [10:0] fld;
    logic [9:0]         ne;
    logic [5:0]         rs;
    mant_t              s;
    logic               stk;
    logic               rnd;
    logic [30:0]        mag;
    es  = {e[9], e};
    lzs = {5'b0, lz};
    fld = 11'sd0;
    stk = 1'b0;
    s   = '0;
    ne  = 10'(-e);
    rs  = ne[5:0];
    if (p == '0) begin
      return {sgn, 31'b0};
    end
    if (es >= lzs) begin
      s   = p << lz;
      fld = es + 11'sd1 - lzs;
    end else if (e >= 0) begin
      s = p << e[5:0];
    end else if (ne >= 10'd48) begin
      stk = |p;
    end else begin
      s   = p >> rs;
      stk = |(p & ~({MANT_W{1'b1}} << rs));
    end
    if (fld >= 11'sd255) begin
      return {sgn, EXP_MAX, 23'b0};
    end
    rnd = s[23] & ((|s[22:0]) | stk | s[24]);
    mag = {fld[7:0], s[46:24]} + {30'b0, rnd};
    return {sgn, mag};
  endfunction

endpackage

/* rtl/fisr_fmul.sv */
// Three-stage single-precision multiplier: product, leading zero count, round and pack.
`timescale 1ns / 1ps
module fisr_fmul
  import fisr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  word_t a_i,
  input  word_t b_i,
  input  word_t tag_i,
  output logic  vld_o,
  output word_t res_o,
  output word_t tag_o
);

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  logic  s1_vld_r, s2_vld_r, s3_vld_r;
  logic  s1_spc_r, s2_spc_r;
  word_t s1_spv_r, s2_spv_r;
  logic  s1_sgn_r, s2_sgn_r;
  sexp_t s1_e_r, s2_e_r;
  mant_t s1_p_r, s2_p_r;
  logic [5:0] s2_lz_r;
  word_t s1_tag_r, s2_tag_r, s3_tag_r, s3_res_r;
  logic  spc_nxt;
  word_t spv_nxt;

  always_comb begin
    a_nan  = (a_i[30:23] == EXP_MAX) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == EXP_MAX) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == EXP_MAX) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == EXP_MAX) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    ma     = {(a_i[30:23] != '0), a_i[22:0]};
    mb     = {(b_i[30:23] != '0), b_i[22:0]};
    ea     = (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
    eb     = (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
    spc_nxt = 1'b0;
    spv_nxt = CANON_NAN;
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      spc_nxt = 1'b1;
    end else if (a_inf || b_inf) begin
      spc_nxt = 1'b1;
      spv_nxt = {a_i[31] ^ b_i[31], EXP_MAX, 23'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spc_r <= spc_nxt;
      s1_spv_r <= spv_nxt;
      s1_sgn_r <= a_i[31] ^ b_i[31];
      s1_e_r   <= sexp_t'({2'b0, ea}) + sexp_t'({2'b0, eb}) - 10'sd127;
      s1_p_r   <= ma * mb;
      s1_tag_r <= tag_i;
      s2_spc_r <= s1_spc_r;
      s2_spv_r <= s1_spv_r;
      s2_sgn_r <= s1_sgn_r;
      s2_e_r   <= s1_e_r;
      s2_p_r   <= s1_p_r;
      s2_lz_r  <= lzc48(s1_p_r);
      s2_tag_r <= s1_tag_r;
      s3_res_r <= s2_spc_r ? s2_spv_r : fp_pack(s2_sgn_r, s2_e_r, s2_lz_r, s2_p_r);
      s3_tag_r <= s2_tag_r;
    end
  end

  assign vld_o = s3_vld_r;
  assign res_o = s3_res_r;
  assign tag_o = s3_tag_r;

endmodule

/* rtl/fisr_fadd.sv */
// Four-stage single-precision adder: align, add, leading zero count, round and pack.
`timescale 1ns / 1ps
module fisr_fadd
  import fisr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  word_t a_i,
  input  word_t b_i,
  input  word_t tag_i,
  output logic  vld_o,
  output word_t res_o,
  output word_t tag_o
);

  logic a_nan, b_nan, a_inf, b_inf;
  word_t x, y;
  logic [7:0] ex, ey, d;
  mant_t xm, yf, yal;
  logic  stk;
  logic  spc_nxt;
  word_t spv_nxt;
  mant_t sum;

  logic  s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic  s1_spc_r, s2_spc_r, s3_spc_r;
  word_t s1_spv_r, s2_spv_r, s3_spv_r;
  logic  s1_sx_r, s1_sy_r, s2_sgn_r, s3_sgn_r;
  logic [7:0] s1_e_r, s2_e_r, s3_e_r;
  mant_t s1_x_r, s1_y_r, s2_p_r, s3_p_r;
  logic [5:0] s3_lz_r;
  word_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s4_res_r;

  always_comb begin
    a_nan = (a_i[30:23] == EXP_MAX) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == EXP_MAX) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == EXP_MAX) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == EXP_MAX) && (b_i[22:0] == '0);
    spc_nxt = 1'b0;
    spv_nxt = CANON_NAN;
    if (a_nan || b_nan || (a_inf && b_inf && (a_i[31] != b_i[31]))) begin
      spc_nxt = 1'b1;
    end else if (a_inf) begin
      spc_nxt = 1'b1;
      spv_nxt = a_i;
    end else if (b_inf) begin
      spc_nxt = 1'b1;
      spv_nxt = b_i;
    end
    // larger magnitude goes first
    if (a_i[30:0] >= b_i[30:0]) begin
      x = a_i;
      y = b_i;
    end else begin
      x = b_i;
      y = a_i;
    end
    ex  = (x[30:23] == '0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == '0) ? 8'd1 : y[30:23];
    d   = ex - ey;
    xm  = {1'b0, (x[30:23] != '0), x[22:0], 23'b0};
    yf  = {1'b0, (y[30:23] != '0), y[22:0], 23'b0};
    if (d >= 8'd48) begin
      yal = '0;
      stk = |yf;
    end else begin
      yal = yf >> d[5:0];
      stk = |(yf & ~({MANT_W{1'b1}} << d[5:0]));
    end
    yal[0] = yal[0] | stk;
    sum = (s1_sx_r != s1_sy_r) ? (s1_x_r - s1_y_r) : (s1_x_r + s1_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_spc_r <= spc_nxt;
      s1_spv_r <= spv_nxt;
      s1_sx_r  <= x[31];
      s1_sy_r  <= y[31];
      s1_e_r   <= ex;
      s1_x_r   <= xm;
      s1_y_r   <= yal;
      s1_tag_r <= tag_i;
      s2_spc_r <= s1_spc_r;
      s2_spv_r <= s1_spv_r;
      // exact cancellation rounds to +0
      s2_sgn_r <= (sum == '0) ? (s1_sx_r & s1_sy_r) : s1_sx_r;
      s2_e_r   <= s1_e_r;
      s2_p_r   <= sum;
      s2_tag_r <= s1_tag_r;
      s3_spc_r <= s2_spc_r;
      s3_spv_r <= s2_spv_r;
      s3_sgn_r <= s2_sgn_r;
      s3_e_r   <= s2_e_r;
      s3_p_r   <= s2_p_r;
      s3_lz_r  <= lzc48(s2_p_r);
      s3_tag_r <= s2_tag_r;
      s4_res_r <= s3_spc_r ? s3_spv_r
                           : fp_pack(s3_sgn_r, sexp_t'({2'b0, s3_e_r}), s3_lz_r, s3_p_r);
      s4_tag_r <= s3_tag_r;
    end
  end

  assign vld_o = s4_vld_r;
  assign res_o = s4_res_r;
  assign tag_o = s4_tag_r;

endmodule

/* rtl/fast_inverse_square_root_top.sv */
// Top level of the pipelined fast reciprocal square root block.
`timescale 1ns / 1ps
// Usage:
//   Input stream (in_*): one request per accepted beat, in_tdata is the raw
//   IEEE-754 single-precision operand. Output stream (out_*): one result per
//   request, in order, out_tdata is the raw single-precision approximation of
//   1/sqrt(operand) after one Newton step on the 0x5f3759df guess.
//   The path from acceptance to out_tvalid runs through the chain of
//   five float units (multiplier 3 stages, adder 4 stages):
//   half = x*0.5 and guess -> half*y -> (half*y)*y -> 1.5 - that -> y*corr.
//   Throughput: one request per cycle while out_tready is high.
//   Stall: the final multiplier stage is the output register; when it holds
//   a result and out_tready is low, every stage freezes and in_tready drops.
//   Nothing is lost or repeated. in_tready is high whenever the output
//   register is empty, so bubbles drain while the receiver is stalled.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the block
//   accepts requests on the first cycle after reset.
//   Any NaN result is delivered as 0x7fc00000.
module fast_inverse_square_root_top
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);

  logic  en;
  word_t guess;
  logic  v1, v2, v3, v4, v5;
  word_t half, hy, hyy, corr, res;
  word_t y1, y2, y3, y4;

  // whole pipeline advances unless a finished result is held
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  // first guess from the raw bits: arithmetic shift right, subtract from magic
  assign guess = MAGIC_GUESS - {in_tdata[31], in_tdata[31:1]};

  fisr_fmul u_half (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_tvalid),
    .a_i(in_tdata), .b_i(HALF_BITS), .tag_i(guess),
    .vld_o(v1), .res_o(half), .tag_o(y1)
  );

  fisr_fmul u_hy (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v1),
    .a_i(half), .b_i(y1), .tag_i(y1),
    .vld_o(v2), .res_o(hy), .tag_o(y2)
  );

  fisr_fmul u_hyy (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v2),
    .a_i(hy), .b_i(y2), .tag_i(y2),
    .vld_o(v3), .res_o(hyy), .tag_o(y3)
  );

  // 1.5 - hyy as an add with the sign flipped
  fisr_fadd u_corr (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3),
    .a_i(THREE_HALVES), .b_i({~hyy[31], hyy[30:0]}), .tag_i(y3),
    .vld_o(v4), .res_o(corr), .tag_o(y4)
  );

  fisr_fmul u_res (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v4),
    .a_i(y4), .b_i(corr), .tag_i(y4),
    .vld_o(v5), .res_o(res), .tag_o()
  );

  assign out_tvalid = v5;
  assign out_tdata  = res;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the fast reciprocal square root stream block.
`timescale 1ns / 1ps
module testbench;
  import fisr_pkg::*;

  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES  = 40;    // longer than the pipeline latency
  localparam int WATCHDOG_MAX  = 5000;  // cycles with no request or result moving
  localparam word_t SIGN_BIT   = 32'h80000000;

  logic  clk;
  logic  rst_n;
  logic  in_tvalid;
  logic  in_tready;
  word_t in_tdata;    // [31:0] operand_bits
  logic  out_tvalid;
  logic  out_tready;
  word_t out_tdata;   // [31:0] result_bits

  word_t expected_roots[$];   // predicted results, oldest first
  int    failures;
  int    idle_pct;            // chance in percent that a side idles this cycle
  int    hold_left;           // receiver hold-off still to run
  int    quiet_cycles;

  fast_inverse_square_root_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Single-precision arithmetic, round to nearest even, subnormals kept.
  // Values are handled as integer significand times a power of two.
  // ---------------------------------------------------------------------------

  // Round m * 2^e to a single-precision word.
  function automatic word_t round_to_single(input logic sgn, input logic [65:0] m,
                                            input int e);
    int          msb;
    int          sh;
    int          k;
    logic [65:0] q;
    logic        half_bit;
    logic        sticky;
    if (m == '0) return {sgn, 31'b0};
    msb = 0;
    for (int i = 0; i < 66; i++) begin
      if (m[i]) msb = i;
    end
    // keep 24 bits, but never go below the subnormal lsb weight 2^-149
    sh = msb - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh > 0) begin
      if (sh > 66) begin
        q        = '0;
        half_bit = 1'b0;
        sticky   = 1'b1;
      end else begin
        q        = m >> sh;
        half_bit = m[sh-1];
        sticky   = |(m & ((66'd1 << (sh - 1)) - 66'd1));
      end
      if (half_bit && (sticky || q[0])) q = q + 66'd1;
    end else begin
      q = m << (-sh);
    end
    k = e + sh;
    if (q[24]) begin
      q = q >> 1;
      k++;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    if (k + 150 >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, 8'(k + 150), q[22:0]};
  endfunction

  function automatic void split_single(input word_t w, output logic sgn,
                                       output logic [23:0] m, output int e,
                                       output logic is_nan, output logic is_inf);
    sgn    = w[31];
    is_nan = (w[30:23] == 8'hff) && (w[22:0] != '0);
    is_inf = (w[30:23] == 8'hff) && (w[22:0] == '0);
    if (w[30:23] == 8'd0) begin
      m = {1'b0, w[22:0]};
      e = -149;
    end else begin
      m = {1'b1, w[22:0]};
      e = int'(w[30:23]) - 150;
    end
  endfunction

  function automatic word_t single_mul(input word_t a, input word_t b);
    logic        sa, sb, na, nb, ia, ib;
    logic [23:0] ma, mb;
    int          ea, eb;
    split_single(a, sa, ma, ea, na, ia);
    split_single(b, sb, mb, eb, nb, ib);
    if (na || nb) return CANON_NAN;
    if ((ia && mb == '0) || (ib && ma == '0)) return CANON_NAN;
    if (ia || ib) return {sa ^ sb, 8'hff, 23'd0};
    return round_to_single(sa ^ sb, 66'(ma) * 66'(mb), ea + eb);
  endfunction

  function automatic word_t single_add(input word_t a, input word_t b);
    logic        sa, sb, na, nb, ia, ib;
    logic [23:0] ma, mb;
    int          ea, eb;
    int          d;
    int          ez;
    logic [65:0] big_m, tiny_m;
    split_single(a, sa, ma, ea, na, ia);
    split_single(b, sb, mb, eb, nb, ib);
    if (na || nb) return CANON_NAN;
    if (ia && ib && (sa != sb)) return CANON_NAN;
    if (ia) return a;
    if (ib) return b;
    if (ma == '0 && mb == '0) return {sa & sb, 31'b0};
    if (ma == '0) return b;
    if (mb == '0) return a;
    if (ea < eb) begin
      d = eb - ea;
      if (d <= 40) begin
        big_m = 66'(mb) << d; tiny_m = 66'(ma); ez = ea;
      end else begin
        // far-below operand only matters as a sticky bit
        big_m = 66'(mb) << 26; tiny_m = 66'd1; ez = eb - 26;
      end
      if (sa == sb) return round_to_single(sb, big_m + tiny_m, ez);
      return round_to_single(sb, big_m - tiny_m, ez);
    end
    d = ea - eb;
    if (d <= 40) begin
      big_m = 66'(ma) << d; tiny_m = 66'(mb); ez = eb;
    end else begin
      big_m = 66'(ma) << 26; tiny_m = 66'd1; ez = ea - 26;
    end
    if (sa == sb) return round_to_single(sa, big_m + tiny_m, ez);
    if (big_m == tiny_m) return 32'h0;
    if (big_m > tiny_m) return round_to_single(sa, big_m - tiny_m, ez);
    return round_to_single(sb, tiny_m - big_m, ez);
  endfunction

  // Bit-exact expectation: magic guess plus one Newton step.
  function automatic word_t rsqrt_estimate(input word_t x);
    word_t half_x, guess, hy, hyy, corr, root;
    half_x = single_mul(x, HALF_BITS);
    guess  = MAGIC_GUESS - ((x >> 1) | (x & SIGN_BIT));
    hy     = single_mul(half_x, guess);
    hyy    = single_mul(hy, guess);
    corr   = single_add(THREE_HALVES, hyy ^ SIGN_BIT);
    root   = single_mul(guess, corr);
    if (root[30:23] == EXP_MAX && root[22:0] != '0) root = CANON_NAN;
    return root;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        failures++;
      end else begin
        want = expected_roots.pop_front();
        if (out_tdata !== want) begin
          $error("result_bits: expected %h, actual %h", want, out_tdata);
          failures++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one request; idles first at random, holds tvalid until accepted.
  task automatic send_operand(input word_t w);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_roots.push_back(rsqrt_estimate(w));
  endtask

  function automatic word_t random_operand();
    case ($urandom_range(9))
      0:       return {1'b0, 8'd0, 23'($urandom)};                        // subnormal
      1:       return {1'($urandom), 8'hff, 23'($urandom_range(1, 3))};   // NaN
      2:       return {1'b1, 31'($urandom)};                              // negative
      3:       return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
      4:       return {1'b0, 8'($urandom_range(250, 254)), 23'($urandom)};
      5, 6:    return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)}; // everyday range
      default: return $urandom;
    endcase
  endfunction

  // Extremes and special operands: zeros, infinities, NaNs, subnormals, negatives.
  task automatic test_special_operands();
    word_t corner[$];
    corner = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
               32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
               32'h007fffff, 32'h00800000, 32'h7f7fffff, 32'h80000001,
               32'hbf800000, 32'h3f800000, 32'h40800000, 32'h3e800000,
               32'h3f800001, 32'h5f3759df, 32'h00400000, 32'h7effffff,
               32'h3f000000, 32'h42c80000};
    foreach (corner[i]) send_operand(corner[i]);
  endtask

  // Random operands; the first stretch runs with no idling on either side.
  task automatic test_random_operands(input int count);
    idle_pct = 0;
    for (int i = 0; i < count; i++) begin
      if (i == 400) idle_pct = 13;
      send_operand(random_operand());
    end
  endtask

  // Receiver holds off while requests keep coming: the pipeline fills and stalls.
  task automatic test_output_backpressure();
    idle_pct  = 0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) send_operand(random_operand());
    idle_pct = 13;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    out_tready   <= 1'b0;
    failures     = 0;
    idle_pct     = 13;
    hold_left    = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_operands();
    test_output_backpressure();
    test_random_operands(1900);

    in_tvalid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
